>>> hdl/esd_pkg.sv
// ----------------------------------------------------------------------------
// esd_pkg
// Types, character constants and decode helpers of the escape sequence decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package esd_pkg;

  localparam int unsigned CpW     = 21;
  localparam int unsigned CharW   = 32;
  localparam int unsigned PendDepth = 7;
  localparam int unsigned PendIdxW  = 3;

  localparam logic [CpW-1:0] BSLASH = 21'h00005C;

  // Escape letters, and the control characters the simple ones stand for
  localparam logic [CpW-1:0] LTR_T = 21'h74;
  localparam logic [CpW-1:0] LTR_N = 21'h6E;
  localparam logic [CpW-1:0] LTR_R = 21'h72;
  localparam logic [CpW-1:0] LTR_B = 21'h62;
  localparam logic [CpW-1:0] LTR_A = 21'h61;
  localparam logic [CpW-1:0] LTR_F = 21'h66;
  localparam logic [CpW-1:0] LTR_V = 21'h76;
  localparam logic [CpW-1:0] LTR_X = 21'h78;
  localparam logic [CpW-1:0] LTR_U_LO = 21'h75;
  localparam logic [CpW-1:0] LTR_U_HI = 21'h55;

  localparam logic [7:0] CTL_TAB = 8'h09;
  localparam logic [7:0] CTL_LF  = 8'h0A;
  localparam logic [7:0] CTL_CR  = 8'h0D;
  localparam logic [7:0] CTL_BS  = 8'h08;
  localparam logic [7:0] CTL_BEL = 8'h07;
  localparam logic [7:0] CTL_FF  = 8'h0C;
  localparam logic [7:0] CTL_VT  = 8'h0B;
  localparam logic [7:0] CTL_NONE = 8'h00;

  localparam logic [3:0] HEX_NONE = 4'd0;
  localparam logic [3:0] HEX_X    = 4'd2;
  localparam logic [3:0] HEX_U_LO = 4'd4;
  localparam logic [3:0] HEX_U_HI = 4'd8;

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_HEX  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    TM_TEXT = 2'd0,
    TM_ESC  = 2'd1,
    TM_HEX  = 2'd2
  } tail_mode_e;

  typedef struct packed {
    logic [CharW-1:0] out_char;
    logic             has_char;
    logic             run_last;
    logic             string_end;
  } result_t;

  // Value of one hex digit; anything else counts as zero
  function automatic logic [3:0] digit_value(input logic [CpW-1:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c inside {[21'h61:21'h66]}) begin
      v = c[3:0] + 4'd9;
    end else if (c inside {[21'h41:21'h46]}) begin
      v = c[3:0] + 4'd9;
    end else if (c inside {[21'h30:21'h39]}) begin
      v = c[3:0];
    end
    return v;
  endfunction

  // Control character for a simple escape letter, CTL_NONE if none
  function automatic logic [7:0] simple_escape(input logic [CpW-1:0] e);
    logic [7:0] r;
    case (e)
      LTR_T:   r = CTL_TAB;
      LTR_N:   r = CTL_LF;
      LTR_R:   r = CTL_CR;
      LTR_B:   r = CTL_BS;
      LTR_A:   r = CTL_BEL;
      LTR_F:   r = CTL_FF;
      LTR_V:   r = CTL_VT;
      default: r = CTL_NONE;
    endcase
    return r;
  endfunction

  // Number of hex digits that follow a hex escape letter, HEX_NONE if none
  function automatic logic [3:0] hex_count(input logic [CpW-1:0] e);
    logic [3:0] r;
    case (e)
      LTR_X:    r = HEX_X;
      LTR_U_LO: r = HEX_U_LO;
      LTR_U_HI: r = HEX_U_HI;
      default:  r = HEX_NONE;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/escape_sequence_decoder.sv
// ----------------------------------------------------------------------------
// escape_sequence_decoder
// Streaming C-style string unescaper: one code point in, decoded characters out.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------
//  in      | input     | in_valid_i/in_ready_o | code_point_i, last_i
//  out     | output    | out_valid_o/out_ready_i | out_char_o, has_char_o,
//          |           |                       | run_last_o, string_end_o
//
//  One word per cycle unless stalled; each word is decoded in the cycle it is
//  taken and its result lands in a two-word result FIFO the next cycle.
//  A string that ends inside a \x, \u or \U escape replays the n held digits
//  (n at most 7) through the tail sequencer, with in_ready_o low meanwhile.
//  in_ready_o also drops while the result FIFO holds two words.
//  Reset clears mode, counters, the sequencer and the FIFO; held digits keep
//  their contents and are only read after being written.
`timescale 1ns / 1ps

module escape_sequence_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [esd_pkg::CpW-1:0]       code_point_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [esd_pkg::CharW-1:0]     out_char_o,
  output logic                          has_char_o,
  output logic                          run_last_o,
  output logic                          string_end_o
);

  // Main decode state
  esd_pkg::mode_e           mode_q, mode_d;
  logic [3:0]               wanted_q, wanted_d;
  logic [3:0]               seen_q, seen_d;
  logic [esd_pkg::CharW-1:0] acc_q, acc_d;

  // Held hex digits
  logic [esd_pkg::CpW-1:0]  pend_q [esd_pkg::PendDepth];

  // Tail sequencer state
  logic                          busy_q, busy_d;
  logic [esd_pkg::PendIdxW-1:0]  idx_q, idx_d;
  logic [esd_pkg::PendIdxW-1:0]  cnt_n_q, cnt_n_d;
  esd_pkg::tail_mode_e           tmode_q, tmode_d;
  logic [2:0]                    tdig_q, tdig_d;
  logic [15:0]                   tacc_q, tacc_d;
  logic                          hold_vld_q, hold_vld_d;
  logic [esd_pkg::CpW-1:0]       hold_char_q, hold_char_d;

  // Result FIFO
  esd_pkg::result_t fifo_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       fcnt_q;
  logic             fifo_space;
  logic             push, pop;
  esd_pkg::result_t push_data;

  // Main path signals
  logic                      in_acc;
  logic [7:0]                m_ctl;
  logic [3:0]                m_w;
  logic [3:0]                seen_nx;
  logic [esd_pkg::CharW-1:0] acc_nx;
  logic                      m_emit;
  logic [esd_pkg::CharW-1:0] m_char;
  logic                      m_flush;
  logic                      m_push;

  // Tail path signals
  logic [esd_pkg::CpW-1:0]   t_cp;
  logic [7:0]                t_ctl;
  logic [3:0]                t_w;
  logic [15:0]               tacc_nx;
  logic                      s_emit;
  logic [esd_pkg::CpW-1:0]   s_char;
  logic                      s_push;
  esd_pkg::result_t          s_data;
  logic                      s_step;

  assign fifo_space = (fcnt_q != 2'd2);
  assign in_ready_o = !busy_q && fifo_space;
  assign in_acc     = in_valid_i && in_ready_o;
  assign s_step     = busy_q && fifo_space;

  assign m_ctl   = esd_pkg::simple_escape(code_point_i);
  assign m_w     = esd_pkg::hex_count(code_point_i);
  assign seen_nx = seen_q + 4'd1;
  assign acc_nx  = {acc_q[esd_pkg::CharW-5:0], esd_pkg::digit_value(code_point_i)};

  // Decode the incoming word and update the escape state
  always_comb begin
    mode_d   = mode_q;
    wanted_d = wanted_q;
    seen_d   = seen_q;
    acc_d    = acc_q;
    m_emit   = 1'b0;
    m_char   = '0;
    m_flush  = 1'b0;
    if (in_acc) begin
      case (mode_q)
        esd_pkg::MODE_ESC: begin
          mode_d = esd_pkg::MODE_TEXT;
          if (m_ctl != esd_pkg::CTL_NONE) begin
            m_emit = 1'b1;
            m_char = {24'h0, m_ctl};
          end else if (m_w != esd_pkg::HEX_NONE) begin
            if (!last_i) begin
              mode_d   = esd_pkg::MODE_HEX;
              wanted_d = m_w;
              seen_d   = 4'd0;
              acc_d    = '0;
            end
          end else begin
            m_emit = 1'b1;
            m_char = {11'h0, code_point_i};
          end
        end
        esd_pkg::MODE_HEX: begin
          acc_d  = acc_nx;
          seen_d = seen_nx;
          if (seen_nx >= wanted_q) begin
            m_emit = 1'b1;
            m_char = acc_nx;
            mode_d = esd_pkg::MODE_TEXT;
            seen_d = 4'd0;
          end else if (last_i) begin
            m_flush = 1'b1;
          end
        end
        default: begin
          mode_d = esd_pkg::MODE_TEXT;
          if (code_point_i == esd_pkg::BSLASH) begin
            if (!last_i) begin
              mode_d = esd_pkg::MODE_ESC;
            end
          end else begin
            m_emit = 1'b1;
            m_char = {11'h0, code_point_i};
          end
        end
      endcase
      // End of string: back to plain text with counters cleared
      if (last_i) begin
        mode_d   = esd_pkg::MODE_TEXT;
        wanted_d = 4'd0;
        seen_d   = 4'd0;
        acc_d    = '0;
      end
    end
  end

  assign m_push = in_acc && (m_emit || (last_i && !m_flush));

  // Tail sequencer: decode the held digits anew, one per cycle while the FIFO has space
  assign t_cp    = (idx_q < 3'(esd_pkg::PendDepth)) ? pend_q[idx_q] : '0;
  assign t_ctl   = esd_pkg::simple_escape(t_cp);
  assign t_w     = esd_pkg::hex_count(t_cp);
  assign tacc_nx = {tacc_q[11:0], esd_pkg::digit_value(t_cp)};

  always_comb begin
    busy_d      = busy_q;
    idx_d       = idx_q;
    cnt_n_d     = cnt_n_q;
    tmode_d     = tmode_q;
    tdig_d      = tdig_q;
    tacc_d      = tacc_q;
    hold_vld_d  = hold_vld_q;
    hold_char_d = hold_char_q;
    s_emit      = 1'b0;
    s_char      = '0;
    s_push      = 1'b0;
    s_data      = '0;
    if (m_flush) begin
      busy_d     = 1'b1;
      idx_d      = '0;
      cnt_n_d    = seen_nx[esd_pkg::PendIdxW-1:0];
      tmode_d    = esd_pkg::TM_TEXT;
      hold_vld_d = 1'b0;
    end else if (s_step) begin
      if (idx_q == cnt_n_q) begin
        // Close the string with the held character or an end marker
        s_push            = 1'b1;
        s_data.out_char   = hold_vld_q ? {11'h0, hold_char_q} : '0;
        s_data.has_char   = hold_vld_q;
        s_data.run_last   = 1'b1;
        s_data.string_end = 1'b1;
        busy_d            = 1'b0;
        hold_vld_d        = 1'b0;
      end else begin
        idx_d = idx_q + 3'd1;
        case (tmode_q)
          esd_pkg::TM_ESC: begin
            tmode_d = esd_pkg::TM_TEXT;
            if (t_ctl != esd_pkg::CTL_NONE) begin
              s_emit = 1'b1;
              s_char = {13'h0, t_ctl};
            end else if (t_w != esd_pkg::HEX_NONE) begin
              // Take the digits only if they all lie inside the tail
              if (({1'b0, idx_q} + t_w) < {1'b0, cnt_n_q}) begin
                tmode_d = esd_pkg::TM_HEX;
                tdig_d  = t_w[2:0];
                tacc_d  = '0;
              end
            end else begin
              s_emit = 1'b1;
              s_char = t_cp;
            end
          end
          esd_pkg::TM_HEX: begin
            tacc_d = tacc_nx;
            tdig_d = tdig_q - 3'd1;
            if (tdig_q == 3'd1) begin
              s_emit  = 1'b1;
              s_char  = {5'h0, tacc_nx};
              tmode_d = esd_pkg::TM_TEXT;
            end
          end
          default: begin
            tmode_d = esd_pkg::TM_TEXT;
            if (t_cp != esd_pkg::BSLASH) begin
              s_emit = 1'b1;
              s_char = t_cp;
            end else if ((idx_q + 3'd1) != cnt_n_q) begin
              tmode_d = esd_pkg::TM_ESC;
            end
          end
        endcase
        // Release the previous character, hold the new one
        if (s_emit) begin
          if (hold_vld_q) begin
            s_push          = 1'b1;
            s_data.out_char = {11'h0, hold_char_q};
            s_data.has_char = 1'b1;
          end
          hold_vld_d  = 1'b1;
          hold_char_d = s_char;
        end
      end
    end
  end

  // Pick the FIFO write source
  always_comb begin
    push      = m_push || s_push;
    push_data = s_data;
    if (m_push) begin
      push_data.out_char   = m_char;
      push_data.has_char   = m_emit;
      push_data.run_last   = 1'b1;
      push_data.string_end = last_i;
    end
  end

  assign pop          = out_valid_o && out_ready_i;
  assign out_valid_o  = (fcnt_q != 2'd0);
  assign out_char_o   = fifo_q[rd_ptr_q].out_char;
  assign has_char_o   = fifo_q[rd_ptr_q].has_char;
  assign run_last_o   = fifo_q[rd_ptr_q].run_last;
  assign string_end_o = fifo_q[rd_ptr_q].string_end;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= esd_pkg::MODE_TEXT;
      wanted_q   <= 4'd0;
      seen_q     <= 4'd0;
      acc_q      <= '0;
      busy_q     <= 1'b0;
      idx_q      <= '0;
      cnt_n_q    <= '0;
      tmode_q    <= esd_pkg::TM_TEXT;
      tdig_q     <= 3'd0;
      hold_vld_q <= 1'b0;
      wr_ptr_q   <= 1'b0;
      rd_ptr_q   <= 1'b0;
      fcnt_q     <= 2'd0;
    end else begin
      mode_q     <= mode_d;
      wanted_q   <= wanted_d;
      seen_q     <= seen_d;
      acc_q      <= acc_d;
      busy_q     <= busy_d;
      idx_q      <= idx_d;
      cnt_n_q    <= cnt_n_d;
      tmode_q    <= tmode_d;
      tdig_q     <= tdig_d;
      hold_vld_q <= hold_vld_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      fcnt_q <= fcnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    tacc_q      <= tacc_d;
    hold_char_q <= hold_char_d;
    if (push) begin
      fifo_q[wr_ptr_q] <= push_data;
    end
    if (in_acc && (mode_q == esd_pkg::MODE_HEX) &&
        (seen_q < 4'(esd_pkg::PendDepth))) begin
      pend_q[seen_q[esd_pkg::PendIdxW-1:0]] <= code_point_i;
    end
  end

endmodule

>>> hdl/esd_checker.sv
// ----------------------------------------------------------------------------
// esd_props
// Port-level checks of the escape sequence decoder, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module esd_props (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [esd_pkg::CharW-1:0] out_char_i,
  input logic                      has_char_i,
  input logic                      run_last_i,
  input logic                      string_end_i
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_char_i) &&
    $stable(has_char_i) && $stable(run_last_i) && $stable(string_end_i))
    else $error("stalled result word changed");

  // End of string always closes the run of its input word
  a_end_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && string_end_i |-> run_last_i)
    else $error("string end without run end");

  // An empty word only marks the end of a string
  a_marker_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !has_char_i |-> string_end_i && (out_char_i == '0))
    else $error("empty result word outside string end");

  // A word without a character is never followed by its own run continuing
  a_marker_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !has_char_i |-> run_last_i)
    else $error("empty result word not last of its run");

endmodule

bind escape_sequence_decoder esd_props u_esd_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_char_i  (out_char_o),
  .has_char_i  (has_char_o),
  .run_last_i  (run_last_o),
  .string_end_i(string_end_o)
);

>>> sim/esd_checker.sv
// ----------------------------------------------------------------------------
// esd_checker
// Watches both channels of the escape sequence decoder, predicts the decoded
// words from the accepted input words and compares them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module esd_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [esd_pkg::CpW-1:0]   code_point_i,
  input  logic                      last_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [esd_pkg::CharW-1:0] out_char_i,
  input  logic                      has_char_i,
  input  logic                      run_last_i,
  input  logic                      string_end_i,
  output int                        fail_count_o,
  output int                        outstanding_o
);

  // Predicted decoder state
  esd_pkg::mode_e            mode_q;
  logic [3:0]                want_q;
  logic [3:0]                seen_q;
  logic [31:0]               acc_q;
  logic [esd_pkg::CpW-1:0]   held_q [esd_pkg::PendDepth];

  esd_pkg::result_t          decoded_q [$];
  esd_pkg::result_t          due_word;
  esd_pkg::result_t          seen_word;
  int                        fails;

  // Hex digit value; any other code point counts as zero
  function automatic logic [3:0] nibble_of(input logic [esd_pkg::CpW-1:0] c);
    if (c >= 21'h30 && c <= 21'h39) return 4'(c - 21'h30);
    if (c >= 21'h41 && c <= 21'h46) return 4'(c - 21'h37);
    if (c >= 21'h61 && c <= 21'h66) return 4'(c - 21'h57);
    return 4'd0;
  endfunction

  // Control character named by a simple escape letter, zero if none
  function automatic logic [31:0] control_for(input logic [esd_pkg::CpW-1:0] c);
    case (c)
      esd_pkg::LTR_T:   return 32'(esd_pkg::CTL_TAB);
      esd_pkg::LTR_N:   return 32'(esd_pkg::CTL_LF);
      esd_pkg::LTR_R:   return 32'(esd_pkg::CTL_CR);
      esd_pkg::LTR_B:   return 32'(esd_pkg::CTL_BS);
      esd_pkg::LTR_A:   return 32'(esd_pkg::CTL_BEL);
      esd_pkg::LTR_F:   return 32'(esd_pkg::CTL_FF);
      esd_pkg::LTR_V:   return 32'(esd_pkg::CTL_VT);
      default:          return 32'(esd_pkg::CTL_NONE);
    endcase
  endfunction

  // Digit count of a hex escape letter, zero if none
  function automatic logic [3:0] hex_digits_for(input logic [esd_pkg::CpW-1:0] c);
    case (c)
      esd_pkg::LTR_X:    return esd_pkg::HEX_X;
      esd_pkg::LTR_U_LO: return esd_pkg::HEX_U_LO;
      esd_pkg::LTR_U_HI: return esd_pkg::HEX_U_HI;
      default:           return esd_pkg::HEX_NONE;
    endcase
  endfunction

  function automatic esd_pkg::result_t char_word(input logic [31:0] ch, input logic has);
    esd_pkg::result_t r;
    r.out_char   = ch;
    r.has_char   = has;
    r.run_last   = 1'b0;
    r.string_end = 1'b0;
    return r;
  endfunction

  // Advance the predicted state by one input word and queue its decoded words
  task automatic unescape_word(input logic [esd_pkg::CpW-1:0] cp, input logic lst);
    esd_pkg::result_t        res [$];
    logic [31:0]             ctl;
    logic [31:0]             v;
    logic [3:0]              w;
    logic [esd_pkg::CpW-1:0] c;
    logic [esd_pkg::CpW-1:0] e;
    int                      n;
    int                      i;
    int                      j;
    case (mode_q)
      esd_pkg::MODE_ESC: begin
        ctl    = control_for(cp);
        w      = hex_digits_for(cp);
        mode_q = esd_pkg::MODE_TEXT;
        if (ctl != 0) begin
          res.insert(res.size(), char_word(ctl, 1'b1));
        end else if (w != 0) begin
          if (!lst) begin
            mode_q = esd_pkg::MODE_HEX;
            want_q = w;
            seen_q = 4'd0;
            acc_q  = 32'd0;
          end
        end else begin
          res.insert(res.size(), char_word(32'(cp), 1'b1));
        end
      end
      esd_pkg::MODE_HEX: begin
        acc_q = (acc_q << 4) + 32'(nibble_of(cp));
        if (seen_q < 4'(esd_pkg::PendDepth)) held_q[seen_q[2:0]] = cp;
        seen_q = seen_q + 4'd1;
        if (seen_q >= want_q) begin
          res.insert(res.size(), char_word(acc_q, 1'b1));
          mode_q = esd_pkg::MODE_TEXT;
          seen_q = 4'd0;
        end else if (lst) begin
          // String ended early: decode the held digits anew as a string of their own
          n = (seen_q > 4'(esd_pkg::PendDepth)) ? int'(esd_pkg::PendDepth) : int'(seen_q);
          i = 0;
          while (i < n) begin
            c = held_q[i];
            if (c != esd_pkg::BSLASH) begin
              res.insert(res.size(), char_word(32'(c), 1'b1));
            end else if (i + 1 < n) begin
              e   = held_q[i+1];
              ctl = control_for(e);
              w   = hex_digits_for(e);
              if (ctl != 0) begin
                res.insert(res.size(), char_word(ctl, 1'b1));
              end else if (w != 0) begin
                // Drop a hex escape that runs past the held digits
                if (i + 1 + int'(w) < n) begin
                  v = 32'd0;
                  for (j = 0; j < int'(w); j++) begin
                    v = (v << 4) + 32'(nibble_of(held_q[i+2+j]));
                  end
                  res.insert(res.size(), char_word(v, 1'b1));
                  i += int'(w);
                end
              end else begin
                res.insert(res.size(), char_word(32'(e), 1'b1));
              end
              i++;
            end
            i++;
          end
        end
      end
      default: begin
        mode_q = esd_pkg::MODE_TEXT;
        if (cp == esd_pkg::BSLASH) begin
          if (!lst) mode_q = esd_pkg::MODE_ESC;
        end else begin
          res.insert(res.size(), char_word(32'(cp), 1'b1));
        end
      end
    endcase

    // Close the string: an empty end still yields a marker word
    if (lst) begin
      if (res.size() == 0) res.insert(0, char_word(32'd0, 1'b0));
      mode_q = esd_pkg::MODE_TEXT;
      want_q = 4'd0;
      seen_q = 4'd0;
      acc_q  = 32'd0;
    end
    if (res.size() > 0) begin
      res[res.size()-1].run_last   = 1'b1;
      res[res.size()-1].string_end = lst;
    end
    foreach (res[k]) decoded_q.insert(decoded_q.size(), res[k]);
  endtask

  // Predict on input words, compare on output words
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q = esd_pkg::MODE_TEXT;
      want_q = 4'd0;
      seen_q = 4'd0;
      acc_q  = 32'd0;
      fails  = 0;
      decoded_q.delete();
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) unescape_word(code_point_i, last_i);
      if (out_valid_i && out_ready_i) begin
        seen_word.out_char   = out_char_i;
        seen_word.has_char   = has_char_i;
        seen_word.run_last   = run_last_i;
        seen_word.string_end = string_end_i;
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected word: char %h has %b run_last %b end %b", $time,
                   out_char_i, has_char_i, run_last_i, string_end_i);
          fails++;
        end else begin
          due_word = decoded_q.pop_front();
          if (seen_word !== due_word) begin
            $display("%0t: mismatch: expected char %h has %b run_last %b end %b", $time,
                     due_word.out_char, due_word.has_char, due_word.run_last,
                     due_word.string_end);
            $display("%0t:           actual   char %h has %b run_last %b end %b", $time,
                     out_char_i, has_char_i, run_last_i, string_end_i);
            fails++;
          end
        end
      end
      fail_count_o  <= fails;
      outstanding_o <= decoded_q.size();
    end
  end

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives escaped strings into the escape sequence decoder: a directed set of
// escapes and end cases, then random strings, mostly well formed, some cut
// short. Both channels stall at random; the checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  logic                      clk_i        = 1'b0;
  logic                      rst_ni       = 1'b0;
  logic                      in_valid_i   = 1'b0;
  logic                      in_ready_o;
  logic [esd_pkg::CpW-1:0]   code_point_i = '0;
  logic                      last_i       = 1'b0;
  logic                      out_valid_o;
  logic                      out_ready_i  = 1'b0;
  logic [esd_pkg::CharW-1:0] out_char_o;
  logic                      has_char_o;
  logic                      run_last_o;
  logic                      string_end_o;

  int                        fail_count;
  int                        outstanding;
  logic                      steady = 1'b0;   // no stalls on either side while set
  int                        sent   = 0;
  logic [esd_pkg::CpW-1:0]   word_q [$];

  always #10 clk_i = ~clk_i;

  escape_sequence_decoder u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .code_point_i (code_point_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_char_o   (out_char_o),
    .has_char_o   (has_char_o),
    .run_last_o   (run_last_o),
    .string_end_o (string_end_o)
  );

  esd_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .code_point_i  (code_point_i),
    .last_i        (last_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_char_i    (out_char_o),
    .has_char_i    (has_char_o),
    .run_last_i    (run_last_o),
    .string_end_i  (string_end_o),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // Stall the result side about a quarter of the time
  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(0, 99) >= 26);
  end

  // Code point from a random number
  function automatic logic [esd_pkg::CpW-1:0] to_cp(input int unsigned v);
    return v[esd_pkg::CpW-1:0];
  endfunction

  // Append one word to the string under construction
  task automatic add_word(input logic [esd_pkg::CpW-1:0] cp);
    word_q.insert(word_q.size(), cp);
  endtask

  // Offer one word after a random gap and hold it until taken
  task automatic send_word(input logic [esd_pkg::CpW-1:0] cp, input logic lst);
    while (!steady && $urandom_range(0, 99) < 26) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    code_point_i <= cp;
    last_i       <= lst;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  // Send the queued string with the last flag on its final word
  task automatic send_string();
    int k;
    for (k = 0; k < word_q.size(); k++) send_word(word_q[k], k == word_q.size() - 1);
    word_q.delete();
  endtask

  initial begin
    int                      n_tok;
    int                      kind;
    int                      w;
    int                      r;
    int                      cut;
    logic [esd_pkg::CpW-1:0] letter;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Simple escapes, a pass-through escape and the top code point
    word_q = '{esd_pkg::BSLASH, esd_pkg::LTR_T, esd_pkg::BSLASH, esd_pkg::LTR_V,
               esd_pkg::BSLASH, 21'h22, 21'h10FFFF};
    send_string();
    // Eight digits filling the accumulator, with non-hex digits as zero
    word_q = '{esd_pkg::BSLASH, esd_pkg::LTR_U_HI, 21'h66, 21'h46, 21'h39, 21'h61,
               21'h41, 21'h30, 21'h7A, 21'h67};
    send_string();
    // Lone trailing backslash, then a hex letter ending the string
    word_q = '{esd_pkg::BSLASH};
    send_string();
    word_q = '{esd_pkg::BSLASH, esd_pkg::LTR_X};
    send_string();
    // End inside hex digits that hold a new escape
    word_q = '{esd_pkg::BSLASH, esd_pkg::LTR_U_LO, esd_pkg::BSLASH, esd_pkg::LTR_N};
    send_string();
    word_q = '{21'h000000};
    send_string();

    // Random strings built from escape tokens, some cut short
    while (sent < 270) begin
      steady <= (sent >= 120 && sent < 200);
      n_tok = $urandom_range(1, 6);
      repeat (n_tok) begin
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
          if ($urandom_range(0, 3) == 0) add_word(to_cp($urandom_range(0, 21'h10FFFF)));
          else add_word(to_cp($urandom_range(21'h20, 21'h7E)));
        end else if (kind < 55) begin
          case ($urandom_range(0, 6))
            0:       letter = esd_pkg::LTR_T;
            1:       letter = esd_pkg::LTR_N;
            2:       letter = esd_pkg::LTR_R;
            3:       letter = esd_pkg::LTR_B;
            4:       letter = esd_pkg::LTR_A;
            5:       letter = esd_pkg::LTR_F;
            default: letter = esd_pkg::LTR_V;
          endcase
          add_word(esd_pkg::BSLASH);
          add_word(letter);
        end else if (kind < 65) begin
          add_word(esd_pkg::BSLASH);
          add_word(to_cp($urandom_range(0, 21'h10FFFF)));
        end else begin
          case ($urandom_range(0, 2))
            0: begin
              letter = esd_pkg::LTR_X;
              w      = 2;
            end
            1: begin
              letter = esd_pkg::LTR_U_LO;
              w      = 4;
            end
            default: begin
              letter = esd_pkg::LTR_U_HI;
              w      = 8;
            end
          endcase
          add_word(esd_pkg::BSLASH);
          add_word(letter);
          repeat (w) begin
            r = $urandom_range(0, 23);
            if (r < 10) add_word(to_cp(32'h30 + r));
            else if (r < 16) add_word(to_cp(32'h61 + r - 10));
            else if (r < 22) add_word(to_cp(32'h41 + r - 16));
            else add_word(to_cp($urandom_range(0, 21'h10FFFF)));
          end
        end
      end
      // Break some strings: cut them anywhere or leave a dangling backslash
      if ($urandom_range(0, 99) < 30) begin
        cut = $urandom_range(1, word_q.size());
        while (word_q.size() > cut) void'(word_q.pop_back());
      end
      if ($urandom_range(0, 99) < 8) add_word(esd_pkg::BSLASH);
      send_string();
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);

    // Drain the expected words, then watch for strays
    r = 0;
    while (outstanding != 0 && r < 5000) begin
      @(posedge clk_i);
      r++;
    end
    repeat (16) @(posedge clk_i);

    if (fail_count == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (outstanding != 0) $display("%0t: %0d expected words never arrived", $time, outstanding);
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> filelist.f
hdl/esd_pkg.sv
hdl/escape_sequence_decoder.sv
hdl/esd_checker.sv
sim/esd_checker.sv
sim/tb.sv
